@@ src/ptli_pkg.sv @@
// ----------------------------------------------------------------------------
// ptli_pkg
// Shared types and constants of the profile table interpolator.
// ----------------------------------------------------------------------------
package ptli_pkg;

    localparam int NumCols  = 10;
    localparam int ValW     = 32;
    localparam int FracW    = 16;
    localparam int RowW     = NumCols * ValW;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_write,
        t_st_rd_last,
        t_st_chk_last,
        t_st_rd_first,
        t_st_chk_first,
        t_st_rd_seg,
        t_st_chk_seg,
        t_st_div,
        t_st_mul,
        t_st_out
    } t_state;

    // result row source
    typedef enum logic [1:0] {
        t_src_row0,
        t_src_row1,
        t_src_interp
    } t_src;

    // controller to datapath
    typedef struct packed {
        logic      load_in;
        logic      write_row;
        logic      rd_en;
        logic      rd_sel;
        logic      div_start;
        logic      mul_step;
        logic      mul_clear;
        logic      res_load;
        t_src      res_src;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic      kind_query;
        logic      p_gt_k;
        logic      p_lt_k;
        logic      seg_hit;
        logic      p_eq_k0;
        logic      p_eq_k1;
        logic      div_done;
        logic      mul_done;
    } t_sts;

endpackage

@@ src/ptli_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptli_ctrl
// Sequencer: row write, end-point checks, segment scan, divide, multiply.
// ----------------------------------------------------------------------------
module ptli_ctrl #(
    parameter int AW = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_busy,
    input  logic [AW:0]     i_rows,
    input  ptli_pkg::t_sts  i_sts,
    output ptli_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_addr,
    output logic            o_in_ready
);

    ptli_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_seg, n_seg;
    logic [AW-1:0]    w_last;

    assign w_last = AW'(i_rows - 1'b1);

    // hold state and segment index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptli_pkg::t_st_idle;
            r_seg   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_seg      = r_seg;
        o_cmd      = '0;
        o_addr     = r_seg;
        o_in_ready = 1'b0;
        unique case (r_state)
            ptli_pkg::t_st_idle: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ptli_pkg::t_st_write;
                end
            end
            ptli_pkg::t_st_write: begin
                if (!i_sts.kind_query) begin
                    o_cmd.write_row = 1'b1;
                    n_state = ptli_pkg::t_st_idle;
                end else begin
                    n_state = ptli_pkg::t_st_rd_last;
                end
            end
            ptli_pkg::t_st_rd_last: begin
                o_addr       = w_last;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 1'b0;
                n_state = ptli_pkg::t_st_chk_last;
            end
            ptli_pkg::t_st_chk_last: begin
                if (i_sts.p_gt_k) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_row0;
                    n_state = ptli_pkg::t_st_out;
                end else begin
                    n_state = ptli_pkg::t_st_rd_first;
                end
            end
            ptli_pkg::t_st_rd_first: begin
                o_addr       = '0;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 1'b0;
                n_state = ptli_pkg::t_st_chk_first;
            end
            ptli_pkg::t_st_chk_first: begin
                if (i_sts.p_lt_k) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_row0;
                    n_state = ptli_pkg::t_st_out;
                end else begin
                    n_seg   = '0;
                    n_state = ptli_pkg::t_st_rd_seg;
                end
            end
            ptli_pkg::t_st_rd_seg: begin
                // row 0 of the segment sits in bank 0 from the last read
                o_addr       = AW'(r_seg + 1'b1);
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = 1'b1;
                n_state = ptli_pkg::t_st_chk_seg;
            end
            ptli_pkg::t_st_chk_seg: begin
                priority if (i_sts.seg_hit && i_sts.p_eq_k0) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_row0;
                    n_state = ptli_pkg::t_st_out;
                end else if (i_sts.seg_hit && i_sts.p_eq_k1) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_row1;
                    n_state = ptli_pkg::t_st_out;
                end else if (i_sts.seg_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ptli_pkg::t_st_div;
                end else if (AW'(r_seg + 1'b1) == w_last) begin
                    // no segment brackets: last row, now in bank 1
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_row1;
                    n_state = ptli_pkg::t_st_out;
                end else begin
                    // advance: bank 1 becomes bank 0
                    o_cmd.rd_sel = 1'b0;
                    o_cmd.rd_en  = 1'b0;
                    o_cmd.mul_clear = 1'b1;
                    n_seg   = AW'(r_seg + 1'b1);
                    n_state = ptli_pkg::t_st_rd_seg;
                end
            end
            ptli_pkg::t_st_div: begin
                if (i_sts.div_done) begin
                    n_state = ptli_pkg::t_st_mul;
                end
            end
            ptli_pkg::t_st_mul: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = ptli_pkg::t_src_interp;
                    n_state = ptli_pkg::t_st_out;
                end
            end
            ptli_pkg::t_st_out: begin
                if (!i_out_busy) begin
                    n_state = ptli_pkg::t_st_idle;
                end
            end
            default: n_state = ptli_pkg::t_st_idle;
        endcase
    end

    // a query never reaches the multiply without a bracketing segment
    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptli_pkg::t_st_mul) |-> ($past(r_state) == ptli_pkg::t_st_div ||
                                              $past(r_state) == ptli_pkg::t_st_mul))
        else $error("multiply entered out of order");
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptli_pkg::t_st_rd_seg) |-> (r_seg < w_last))
        else $error("segment index past last row");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> (r_state == ptli_pkg::t_st_write))
        else $error("accepted item not taken");

endmodule

@@ src/ptli_dp.sv @@
// ----------------------------------------------------------------------------
// ptli_dp
// Row memory, compare, serial divider, sequential multiply and result hold.
// ----------------------------------------------------------------------------
module ptli_dp #(
    parameter int AW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptli_pkg::t_cmd            i_cmd,
    input  logic [AW-1:0]             i_addr,
    input  logic                      i_kind,
    input  logic [5:0]                i_entry_index,
    input  logic [ptli_pkg::RowW-1:0] i_row,
    input  logic                      i_out_ready,
    output ptli_pkg::t_sts            o_sts,
    output logic                      o_out_valid,
    output logic [ptli_pkg::RowW-1:0] o_out_row
);

    localparam int VW = ptli_pkg::ValW;
    localparam int NC = ptli_pkg::NumCols;
    localparam int FW = ptli_pkg::FracW;

    logic [ptli_pkg::RowW-1:0] r_mem [2**AW];
    logic [ptli_pkg::RowW-1:0] r_in_row;
    logic                      r_kind;
    logic [5:0]                r_idx;
    logic [ptli_pkg::RowW-1:0] r_b0, r_b1;
    logic signed [VW-1:0]      w_p, w_k0, w_k1;
    logic [VW:0]               r_rem, r_den;
    logic [FW-1:0]             r_t;
    logic [4:0]                r_div_cnt;
    logic                      r_div_busy, r_div_done;
    logic [3:0]                r_mul_cnt;
    logic [ptli_pkg::RowW-1:0] r_acc, r_res;
    logic                      r_out_v;
    logic signed [VW:0]        w_dv;
    logic signed [VW+FW+1:0]   w_prod;
    logic [VW:0]               w_sub;
    logic [AW-1:0]             w_widx;

    assign w_p    = r_in_row[VW-1:0];
    assign w_k0   = r_b0[VW-1:0];
    assign w_k1   = r_b1[VW-1:0];
    assign w_widx = AW'(r_idx);

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_row <= i_row;
            r_kind   <= i_kind;
            r_idx    <= i_entry_index;
        end
    end

    // row memory: one write port, one registered read straight into a bank;
    // shift bank 1 down on advance, rotate both banks on each multiply step
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_row && ({{(32-6){1'b0}}, r_idx} < 32'(2**AW))) begin
            r_mem[w_widx] <= r_in_row;
        end
        if (i_cmd.rd_en && !i_cmd.rd_sel) begin
            r_b0 <= r_mem[i_addr];
        end else if (i_cmd.mul_clear) begin
            r_b0 <= r_b1;
        end else if (i_cmd.mul_step) begin
            r_b0 <= {r_b0[VW-1:0], r_b0[ptli_pkg::RowW-1:2*VW], r_b0[VW +: VW]};
        end
        if (i_cmd.rd_en && i_cmd.rd_sel) begin
            r_b1 <= r_mem[i_addr];
        end else if (i_cmd.mul_step) begin
            r_b1 <= {r_b1[VW-1:0], r_b1[ptli_pkg::RowW-1:2*VW], r_b1[VW +: VW]};
        end
    end

    // compares
    always_comb begin
        o_sts.kind_query = r_kind;
        o_sts.p_gt_k     = w_p > w_k0;
        o_sts.p_lt_k     = w_p < w_k0;
        o_sts.seg_hit    = (w_k0 <= w_p) && (w_k1 >= w_p);
        o_sts.p_eq_k0    = w_p == w_k0;
        o_sts.p_eq_k1    = w_p == w_k1;
        o_sts.div_done   = r_div_done;
        o_sts.mul_done   = r_mul_cnt == 4'(NC - 2);
    end

    // restoring divider, one quotient bit a cycle
    assign w_sub = {r_rem[VW-1:0], 1'b0} - r_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_rem      <= {w_p[VW-1], w_p} - {w_k0[VW-1], w_k0};
                r_den      <= {w_k1[VW-1], w_k1} - {w_k0[VW-1], w_k0};
                r_t        <= '0;
                r_div_cnt  <= '0;
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                if (!w_sub[VW]) begin
                    r_rem <= w_sub;
                    r_t   <= {r_t[FW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[VW-1:0], 1'b0};
                    r_t   <= {r_t[FW-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == 5'(FW - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    // one column a cycle: v0 + floor(t * (v1 - v0) / 2^16)
    assign w_dv   = (VW+1)'($signed(r_b1[VW +: VW])) - (VW+1)'($signed(r_b0[VW +: VW]));
    assign w_prod = $signed({1'b0, r_t}) * w_dv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_cnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_mul_cnt <= r_mul_cnt + 1'b1;
            r_acc <= {VW'($signed(r_b0[VW +: VW]) + w_prod[VW+FW-1:FW]),
                      r_acc[ptli_pkg::RowW-1:VW]};
        end else begin
            r_mul_cnt <= '0;
        end
    end

    // result hold; source selects a row bank or the interpolated row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_src)
                ptli_pkg::t_src_row0:   r_res <= r_b0;
                ptli_pkg::t_src_row1:   r_res <= r_b1;
                ptli_pkg::t_src_interp:
                    r_res <= {VW'($signed(r_b0[VW +: VW]) + w_prod[VW+FW-1:FW]),
                              r_acc[ptli_pkg::RowW-1:2*VW], w_p};
                default:                r_res <= r_b0;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_row   = r_res;

endmodule

@@ src/profile_table_linear_interp.sv @@
// ----------------------------------------------------------------------------
// profile_table_linear_interp
// Profile table with piecewise linear interpolation of nine values.
// ----------------------------------------------------------------------------
// A write item stores one row in the row memory. A query first checks the
// position against the last key, then against the first, and ends there
// when it lies above the last or below the first. Otherwise the segments
// are scanned in order, each with one memory read and one compare; a query
// settled at a segment either returns a row, when the position equals a key
// or no segment brackets it, or interpolates, using the one-bit-a-cycle
// divider and then the column multiplier. One item is in work at a time;
// the result is held in an output register and the next item is taken once
// it has gone, so any receiver stall delays the next item.
module profile_table_linear_interp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [327:0]  s_axis_tdata,  // entry_index, position, val_u .. val_eps
    input  logic          s_axis_tuser,  // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [319:0]  m_axis_tdata,  // out_position, out_u .. out_eps
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [6:0]    i_cfg_data     // row_count
);

    localparam int AW = $clog2(TABLE_DEPTH);

    ptli_pkg::t_cmd w_cmd;
    ptli_pkg::t_sts w_sts;
    logic [AW-1:0]  w_addr;
    logic [AW:0]    w_rows;
    logic [6:0]     r_row_count;
    logic           w_in_ready;

    // hold row count, clamp into range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 7'd2;
        end else if (i_cfg_valid) begin
            r_row_count <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;
    always_comb begin
        priority if (r_row_count < 7'd2) begin
            w_rows = (AW+1)'(2);
        end else if (32'(r_row_count) > TABLE_DEPTH) begin
            w_rows = (AW+1)'(TABLE_DEPTH);
        end else begin
            w_rows = (AW+1)'(r_row_count);
        end
    end

    assign s_axis_tready = w_in_ready;

    ptli_ctrl #(.AW(AW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && w_in_ready),
        .i_out_busy (m_axis_tvalid && !m_axis_tready),
        .i_rows     (w_rows),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .o_in_ready (w_in_ready)
    );

    ptli_dp #(.AW(AW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_addr        (w_addr),
        .i_kind        (s_axis_tuser),
        .i_entry_index (s_axis_tdata[5:0]),
        .i_row         (s_axis_tdata[325:6]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_row     (m_axis_tdata)
    );

endmodule
